[rtl/uvfa_pkg.sv]
// Shared constants, types and the arctangent table for the angle-to-unit-vector block.
// No dependencies; every other file in rtl/ imports this package.
package uvfa_pkg;

  // Pipeline depth and output format
  localparam int ITERATIONS    = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int MAX_STAGES    = 24;
  localparam int NUM_STAGES    = (ITERATIONS < MAX_STAGES) ? ITERATIONS : MAX_STAGES;

  // Field widths
  localparam int ANG_W   = 16;
  localparam int OUT_W   = 16;
  localparam int RED_W   = ANG_W + 1;

  // Datapath formats: x/y carry 32 fraction bits; z counts 2^-24 degree
  localparam int XY_FRAC = 32;
  localparam int XY_W    = XY_FRAC + 2;
  localparam int Z_W     = 32;
  localparam int ANG_TO_Z_SH = 18;

  // Output rounding
  localparam int RND_SH  = XY_FRAC - OUT_FRAC_BITS;
  localparam int RND_W   = XY_W + 1 - RND_SH;
  localparam int EXT_W   = (RND_W > OUT_W) ? RND_W : OUT_W;

  // Angle constants in 1/64 degree
  localparam logic signed [RED_W-1:0] DEG360 = RED_W'(23040);
  localparam logic signed [RED_W-1:0] DEG180 = RED_W'(11520);
  localparam logic signed [RED_W-1:0] DEG90  = RED_W'(5760);

  // Start value: CORDIC limit gain, 0.60725293500888 * 2^32
  localparam longint K_START_L = 64'sd2608131496;
  localparam logic signed [XY_W-1:0] K_START = XY_W'(K_START_L);

  // atan(2^-i) in units of 1e-10 degree; scaled to 2^-24 degree per stage
  localparam longint ATAN_SRC [MAX_STAGES] = '{
    64'sd450000000000, 64'sd265650511771, 64'sd140362434679,
    64'sd71250163489,  64'sd35763343750,  64'sd17899106082,
    64'sd8951737102,   64'sd4476141709,   64'sd2238105004,
    64'sd1119056771,   64'sd559528919,    64'sd279764526,
    64'sd139882271,    64'sd69941137,     64'sd34970569,
    64'sd17485284,     64'sd8742642,      64'sd4371321,
    64'sd2185661,      64'sd1092830,      64'sd546415,
    64'sd273208,       64'sd136604,       64'sd68302
  };
  localparam longint Z_SCALE = 64'sd16777216;
  localparam longint SRC_HALF = 64'sd5000000000;
  localparam longint SRC_UNIT = 64'sd10000000000;

  // One word in flight through the rotation stages
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   neg;
  } cordic_t;

endpackage

[rtl/unit_vector_from_angle_unit.sv]
// Angle to unit vector: cosine and sine of an angle in 1/64 degree, as Q1.14.
// Takes one word per cycle unless output back-pressure has filled the stages. Each word
// passes a register of angle reduction and folding, one register per CORDIC iteration
// and a register of rounding and clamping. Every stage has its own valid bit and ready
// term, so a stalled output only holds the words behind it and empty stages keep
// filling. Depends on uvfa_pkg, uvfa_reduce, uvfa_cordic and uvfa_round.
module unit_vector_from_angle_unit
  import uvfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [ANG_W-1:0]     s_axis_tdata,   // [15:0] angle_deg
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [2*OUT_W-1:0]   m_axis_tdata    // [15:0] cos_out, [31:16] sin_out
);

  logic             red_valid;
  logic             red_ready;
  cordic_t          red_data;
  logic             cor_valid;
  logic             cor_ready;
  cordic_t          cor_data;
  logic [OUT_W-1:0] cos_out;
  logic [OUT_W-1:0] sin_out;

  uvfa_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .angle_deg (s_axis_tdata),
    .out_valid (red_valid),
    .out_ready (red_ready),
    .out_data  (red_data)
  );

  uvfa_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (red_valid),
    .in_ready  (red_ready),
    .in_data   (red_data),
    .out_valid (cor_valid),
    .out_ready (cor_ready),
    .out_data  (cor_data)
  );

  uvfa_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cor_valid),
    .in_ready  (cor_ready),
    .in_data   (cor_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cos_out   (cos_out),
    .sin_out   (sin_out)
  );

  assign m_axis_tdata = {sin_out, cos_out};

endmodule

[rtl/uvfa_reduce.sv]
// Input stage: reduces the angle into -180..180 degrees, folds it into -90..90
// and loads the CORDIC start vector. Depends on uvfa_pkg.
module uvfa_reduce
  import uvfa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ANG_W-1:0] angle_deg,
  output logic             out_valid,
  input  logic             out_ready,
  output cordic_t          out_data
);

  logic                      en;
  logic signed [RED_W-1:0]   a_ext;
  logic signed [RED_W-1:0]   a_red;
  logic signed [RED_W-1:0]   a_fold;
  logic                      fold_neg;
  logic signed [Z_W-1:0]     z_start;
  cordic_t                   data_next;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    a_ext = $signed({angle_deg[ANG_W-1], angle_deg});
    if (a_ext > DEG180) begin
      a_red = a_ext - DEG360;
    end else if (a_ext < -DEG180) begin
      a_red = a_ext + DEG360;
    end else begin
      a_red = a_ext;
    end
    // Fold the left half plane over; both outputs flip sign at the end
    if (a_red > DEG90) begin
      a_fold   = a_red - DEG180;
      fold_neg = 1'b1;
    end else if (a_red < -DEG90) begin
      a_fold   = a_red + DEG180;
      fold_neg = 1'b1;
    end else begin
      a_fold   = a_red;
      fold_neg = 1'b0;
    end
    z_start = $signed({{(Z_W-RED_W){a_fold[RED_W-1]}}, a_fold}) <<< ANG_TO_Z_SH;
    data_next.x   = K_START;
    data_next.y   = '0;
    data_next.z   = z_start;
    data_next.neg = fold_neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

[rtl/uvfa_cordic.sv]
// Unrolled rotation-mode CORDIC, one register stage per iteration, with a
// per-stage ready chain so bubbles close up under backpressure. Depends on uvfa_pkg.
module uvfa_cordic
  import uvfa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  cordic_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output cordic_t out_data
);

  logic    [NUM_STAGES-1:0] vld;
  logic    [NUM_STAGES-1:0] en;
  cordic_t                  st [NUM_STAGES];

  // A stage may load when it is empty or the one after it moves
  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NUM_STAGES-1];
  assign out_data  = st[NUM_STAGES-1];

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    localparam longint ATAN_L = (ATAN_SRC[k] * Z_SCALE + SRC_HALF) / SRC_UNIT;
    localparam logic signed [Z_W-1:0] ATAN_K = Z_W'(ATAN_L);

    cordic_t                src;
    logic                   src_valid;
    cordic_t                nxt;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    if (k == 0) begin : g_first
      assign src       = in_data;
      assign src_valid = in_valid;
    end else begin : g_rest
      assign src       = st[k-1];
      assign src_valid = vld[k-1];
    end

    always_comb begin
      dx = $signed(src.y) >>> k;
      dy = $signed(src.x) >>> k;
      nxt.neg = src.neg;
      // Rotate toward zero residual angle
      if (!src.z[Z_W-1]) begin
        nxt.x = src.x - dx;
        nxt.y = src.y + dy;
        nxt.z = src.z - ATAN_K;
      end else begin
        nxt.x = src.x + dx;
        nxt.y = src.y - dy;
        nxt.z = src.z + ATAN_K;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k] && src_valid) begin
        st[k] <= nxt;
      end
    end
  end

endmodule

[rtl/uvfa_round.sv]
// Output stage: undoes the half-plane fold, rounds x and y to the output format,
// clamps to plus or minus one and holds the result word. Depends on uvfa_pkg.
module uvfa_round
  import uvfa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cordic_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] cos_out,
  output logic [OUT_W-1:0] sin_out
);

  localparam logic signed [XY_W:0]    HALF = (XY_W + 1)'(1) << (RND_SH - 1);
  localparam logic signed [RND_W-1:0] ONE  = RND_W'(1) << OUT_FRAC_BITS;

  logic             en;
  logic [OUT_W-1:0] cos_next;
  logic [OUT_W-1:0] sin_next;

  function automatic logic [OUT_W-1:0] finish(logic signed [XY_W-1:0] v);
    logic signed [XY_W:0]    sum;
    logic signed [RND_W-1:0] r;
    logic signed [EXT_W-1:0] r_ext;
    sum = $signed({v[XY_W-1], v}) + HALF;
    r   = $signed(sum[XY_W:RND_SH]);
    if (r > ONE) begin
      r = ONE;
    end else if (r < -ONE) begin
      r = -ONE;
    end
    r_ext = EXT_W'(r);
    return r_ext[OUT_W-1:0];
  endfunction

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    if (in_data.neg) begin
      cos_next = finish(-in_data.x);
      sin_next = finish(-in_data.y);
    end else begin
      cos_next = finish(in_data.x);
      sin_next = finish(in_data.y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      cos_out <= cos_next;
      sin_out <= sin_next;
    end
  end

endmodule

[rtl/uvfa_checker.sv]
// Port-level checks for unit_vector_from_angle_unit, attached by bind.
// Depends on uvfa_pkg.
module uvfa_checker
  import uvfa_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [2*OUT_W-1:0] m_axis_tdata
);

  localparam logic signed [OUT_W-1:0] ONE_OUT = OUT_W'(1) << OUT_FRAC_BITS;

  logic signed [OUT_W-1:0] cos_s;
  logic signed [OUT_W-1:0] sin_s;

  assign cos_s = $signed(m_axis_tdata[OUT_W-1:0]);
  assign sin_s = $signed(m_axis_tdata[2*OUT_W-1:OUT_W]);

  // A word waiting at the output holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // With the output register empty, every stage can advance
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (OUT_FRAC_BITS <= 14) |->
      cos_s <= ONE_OUT && cos_s >= -ONE_OUT && sin_s <= ONE_OUT && sin_s >= -ONE_OUT)
    else $error("result outside plus or minus one");

endmodule

bind unit_vector_from_angle_unit uvfa_checker u_uvfa_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/unit_vector_from_angle_unit_tb.sv]
// Testbench for unit_vector_from_angle_unit: drives angles on the input stream and
// checks every cosine/sine word against a fixed-point CORDIC predictor.
// Depends on uvfa_pkg and the RTL of unit_vector_from_angle_unit.
module unit_vector_from_angle_unit_tb;
  import uvfa_pkg::*;

  typedef struct packed {
    logic [ANG_W-1:0] angle;
    logic [OUT_W-1:0] cos_fx;
    logic [OUT_W-1:0] sin_fx;
  } unit_vec_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [ANG_W-1:0]     s_axis_tdata = '0;   // [15:0] angle_deg
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [2*OUT_W-1:0]   m_axis_tdata;        // [15:0] cos_out, [31:16] sin_out

  unit_vec_t pending_vecs[$];
  int        mismatches = 0;
  bit        steady = 1'b0;

  unit_vector_from_angle_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // atan(2^-i) in 2^-24 degree, rounded to nearest
  function automatic longint atan_step(int i);
    return (ATAN_SRC[i] * Z_SCALE + SRC_HALF) / SRC_UNIT;
  endfunction

  // Round half up to the output format, clamp to +/-1, keep the low bits
  function automatic logic [OUT_W-1:0] round_to_out(longint v);
    longint r;
    longint one;
    one = longint'(1) << OUT_FRAC_BITS;
    r = (v + (longint'(1) << (RND_SH - 1))) >>> RND_SH;
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[OUT_W-1:0];
  endfunction

  function automatic unit_vec_t unit_vector_of(logic [ANG_W-1:0] ang);
    unit_vec_t v;
    longint a, x, y, z, dx, dy;
    bit neg;
    a = longint'($signed(ang));
    neg = 1'b0;
    if (a > 11520) a -= 23040;
    if (a < -11520) a += 23040;
    // fold into -90..+90 and flip both outputs
    if (a > 5760) begin
      a -= 11520;
      neg = 1'b1;
    end else if (a < -5760) begin
      a += 11520;
      neg = 1'b1;
    end
    x = K_START_L;
    y = 0;
    z = a <<< ANG_TO_Z_SH;
    for (int i = 0; i < ITERATIONS && i < MAX_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_step(i);
      end else begin
        x += dx;
        y -= dy;
        z += atan_step(i);
      end
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    v.angle  = ang;
    v.cos_fx = round_to_out(x);
    v.sin_fx = round_to_out(y);
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offer one angle word, outside the steady stream sometimes after a random idle gap; hold it until the block takes it
  task automatic send_angle(input logic [ANG_W-1:0] ang);
    if (!steady && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ang;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_vecs.push_back(unit_vector_of(ang));
  endtask

  // Check each result word and randomly stall the output side
  always @(posedge clk) begin
    unit_vec_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_vecs.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
        end else begin
          want = pending_vecs.pop_front();
          if (m_axis_tdata[OUT_W-1:0] !== want.cos_fx)
            report_mismatch($sformatf("angle %h cos got %h want %h", want.angle,
                                      m_axis_tdata[OUT_W-1:0], want.cos_fx));
          if (m_axis_tdata[2*OUT_W-1:OUT_W] !== want.sin_fx)
            report_mismatch($sformatf("angle %h sin got %h want %h", want.angle,
                                      m_axis_tdata[2*OUT_W-1:OUT_W], want.sin_fx));
        end
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 17);
    end
  end

  // Field extremes, exact quadrant and half-turn angles and their neighbors
  task automatic test_special_angles();
    logic [ANG_W-1:0] angles[$];
    angles = {16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
              16'(11520), 16'(-11520), 16'(11521), 16'(-11521), 16'(11519),
              16'(-11519), 16'(5760), 16'(-5760), 16'(5761), 16'(-5761),
              16'(5759), 16'(23040), 16'(-23040), 16'(2880), 16'(17280),
              16'(-17280), 16'h5555, 16'hAAAA};
    foreach (angles[i]) send_angle(angles[i]);
  endtask

  // Mostly uniform angles, some clustered at the reduction and fold boundaries
  task automatic test_random_angles(input int count);
    int bases[9];
    int ang;
    bases = '{0, 5760, -5760, 11520, -11520, 17280, -17280, 23040, -23040};
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 70) begin
        ang = $urandom_range(65535);
      end else begin
        ang = bases[$urandom_range(8)] + $signed($urandom_range(8)) - 4;
      end
      send_angle(16'(ang));
    end
  endtask

  // Back-to-back words with the output always ready
  task automatic test_steady_stream(input int count);
    steady = 1'b1;
    test_random_angles(count);
    steady = 1'b0;
  endtask

  initial begin
    int waited;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_angles();
    test_random_angles(600);
    test_steady_stream(300);
    test_random_angles(525);
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_vecs.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (NUM_STAGES + 4) @(posedge clk);
    if (pending_vecs.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_vecs.size()));
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
rtl/uvfa_pkg.sv
rtl/uvfa_reduce.sv
rtl/uvfa_cordic.sv
rtl/uvfa_round.sv
rtl/unit_vector_from_angle_unit.sv
rtl/uvfa_checker.sv
tb/unit_vector_from_angle_unit_tb.sv
